// ----- rtl/trs_pkg.sv -----
// Shared types, constants and the saturation helper of the TRS inverse-matrix block.
`default_nettype none

package trs_pkg;

    // Q16.16 element, Q4.28 rotation entry, Q8.24 reciprocal
    typedef logic signed [31:0] t_word;
    typedef logic        [31:0] t_recip;
    typedef logic signed [15:0] t_quat;

    typedef t_word  t_mat   [3][3];
    typedef t_word  t_vec   [3];
    typedef t_recip t_rvec  [3];
    typedef t_word  t_cols  [4][3];

    localparam int unsigned QBITS       = 33;  // quotient bits of 2^32 / scale
    localparam int unsigned DIV_BITS    = 4;   // quotient bits per divider stage
    localparam int unsigned DIV_STAGES  = (QBITS + DIV_BITS - 1) / DIV_BITS;
    localparam int unsigned ROT_STAGES  = 2;
    localparam int unsigned COL_STAGES  = 5;
    localparam int unsigned PIPE_STAGES = 1 + DIV_STAGES + ROT_STAGES + COL_STAGES;

    localparam logic [31:0] RECIP_MAX = 32'hFFFF_FFFF;
    localparam logic [1:0]  COL_LAST  = 2'd3;
    localparam logic [16:0] ELEM_ONE  = 17'h1_0000;

    function automatic t_word sat32(input logic signed [63:0] x);
        t_word r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/trs_recip.sv -----
// Pipelined restoring divider: floor(2^32 / scale), saturated to 32 bits.
`default_nettype none

module trs_recip (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_scale,
    output trs_pkg::t_recip  o_recip
);

    logic [15:0]              r_rem [trs_pkg::DIV_STAGES];
    logic [15:0]              r_s   [trs_pkg::DIV_STAGES];
    logic [trs_pkg::QBITS-1:0] r_q  [trs_pkg::DIV_STAGES];

    for (genvar g = 0; g < trs_pkg::DIV_STAGES; g++) begin : g_st
        logic [15:0]               c_rem_in;
        logic [15:0]               c_s;
        logic [trs_pkg::QBITS-1:0] c_q_in;
        logic [15:0]               n_rem;
        logic [trs_pkg::QBITS-1:0] n_q;

        if (g == 0) begin : g_first
            assign c_rem_in = '0;
            assign c_s      = i_scale;
            assign c_q_in   = '0;
        end else begin : g_next
            assign c_rem_in = r_rem[g-1];
            assign c_s      = r_s[g-1];
            assign c_q_in   = r_q[g-1];
        end

        always_comb begin
            logic [16:0] t;
            logic        qb;
            n_rem = c_rem_in;
            n_q   = c_q_in;
            for (int j = 0; j < trs_pkg::DIV_BITS; j++) begin
                if (g * trs_pkg::DIV_BITS + j < trs_pkg::QBITS) begin
                    // dividend is 2^32: only the first bit shifted in is one
                    t  = {n_rem, (g == 0 && j == 0)};
                    qb = (t >= {1'b0, c_s});
                    if (qb) begin
                        t = t - {1'b0, c_s};
                    end
                    n_rem = t[15:0];
                    n_q   = {n_q[trs_pkg::QBITS-2:0], qb};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_s[g]   <= c_s;
                r_q[g]   <= n_q;
            end
        end
    end

    // quotient of 2^32 itself (scale 1/256) or all ones (scale zero) clips
    assign o_recip = r_q[trs_pkg::DIV_STAGES-1][trs_pkg::QBITS-1]
                   ? trs_pkg::RECIP_MAX : r_q[trs_pkg::DIV_STAGES-1][31:0];

endmodule

`default_nettype wire

// ----- rtl/trs_rot.sv -----
// Quaternion to 3x3 rotation matrix, two register stages, Q4.28 saturated.
`default_nettype none

module trs_rot (
    input  wire logic   i_clk,
    input  wire logic   i_en,
    input  wire trs_pkg::t_quat i_qx,
    input  wire trs_pkg::t_quat i_qy,
    input  wire trs_pkg::t_quat i_qz,
    input  wire trs_pkg::t_quat i_qw,
    output trs_pkg::t_mat       o_rot
);

    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [34:0] c_e [3][3];
    localparam logic signed [34:0] ONE = 35'sd268435456;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= i_qx * i_qx;
            r_yy <= i_qy * i_qy;
            r_zz <= i_qz * i_qz;
            r_xy <= i_qx * i_qy;
            r_xz <= i_qx * i_qz;
            r_yz <= i_qy * i_qz;
            r_wx <= i_qw * i_qx;
            r_wy <= i_qw * i_qy;
            r_wz <= i_qw * i_qz;
        end
    end

    always_comb begin
        c_e[0][0] = ONE - ((35'(r_yy) + 35'(r_zz)) <<< 1);
        c_e[0][1] = (35'(r_xy) - 35'(r_wz)) <<< 1;
        c_e[0][2] = (35'(r_xz) + 35'(r_wy)) <<< 1;
        c_e[1][0] = (35'(r_xy) + 35'(r_wz)) <<< 1;
        c_e[1][1] = ONE - ((35'(r_xx) + 35'(r_zz)) <<< 1);
        c_e[1][2] = (35'(r_yz) - 35'(r_wx)) <<< 1;
        c_e[2][0] = (35'(r_xz) - 35'(r_wy)) <<< 1;
        c_e[2][1] = (35'(r_yz) + 35'(r_wx)) <<< 1;
        c_e[2][2] = ONE - ((35'(r_xx) + 35'(r_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    o_rot[r][c] <= trs_pkg::sat32({{29{c_e[r][c][34]}}, c_e[r][c]});
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/trs_col.sv -----
// Column arithmetic: scaled rotation columns and the translation column, five stages.
`default_nettype none

module trs_col (
    input  wire logic   i_clk,
    input  wire logic   i_en,
    input  wire trs_pkg::t_mat  i_rot,
    input  wire trs_pkg::t_vec  i_trans,
    input  wire trs_pkg::t_rvec i_recip,
    output trs_pkg::t_cols      o_col
);

    logic signed [64:0] r_pm   [3][3];   // rot[c][i] * recip[i], Q.52
    logic signed [63:0] r_pt   [3][3];   // rot[j][i] * trans[j], Q.44
    trs_pkg::t_rvec     r_rc1, r_rc2;
    trs_pkg::t_word     r_c1 [3][3];
    trs_pkg::t_word     r_c2 [3][3];
    trs_pkg::t_word     r_c3 [3][3];
    logic signed [45:0] r_sum [3];
    logic signed [55:0] r_ph  [3];
    logic        [54:0] r_pl  [3];
    logic signed [46:0] r_q   [3];

    logic signed [64:0] c_pr  [3][3];
    logic signed [45:0] c_sum [3];
    logic signed [46:0] c_q   [3];

    // stage 1: all products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                for (int i = 0; i < 3; i++) begin
                    r_pm[c][i] <= i_rot[c][i] * $signed({1'b0, i_recip[i]});
                    r_pt[c][i] <= i_rot[c][i] * i_trans[c];
                end
            end
            r_rc1 <= i_recip;
        end
    end

    // stage 2: round columns 0..2, round and sum the translation terms
    always_comb begin
        logic signed [63:0] t;
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 3; i++) begin
                c_pr[c][i] = (r_pm[c][i] + (65'sd1 <<< 35)) >>> 36;
            end
        end
        for (int i = 0; i < 3; i++) begin
            c_sum[i] = '0;
            for (int j = 0; j < 3; j++) begin
                t = (r_pt[j][i] + (64'sd1 <<< 19)) >>> 20;
                c_sum[i] = c_sum[i] + $signed({{2{t[43]}}, t[43:0]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                for (int i = 0; i < 3; i++) begin
                    r_c1[c][i] <= trs_pkg::sat32(c_pr[c][i][63:0]);
                end
            end
            r_sum <= c_sum;
            r_rc2 <= r_rc1;
        end
    end

    // stage 3: split the wide sum into two partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_ph[i] <= $signed(r_sum[i][45:23]) * $signed({1'b0, r_rc2[i]});
                r_pl[i] <= r_sum[i][22:0] * r_rc2[i];
            end
            r_c2 <= r_c1;
        end
    end

    // stage 4: recombine and round Q.48 to Q16.16
    always_comb begin
        logic signed [79:0] p;
        logic signed [79:0] s;
        for (int i = 0; i < 3; i++) begin
            p      = ($signed({{24{r_ph[i][55]}}, r_ph[i]}) <<< 23)
                   + $signed({25'b0, r_pl[i]});
            s      = (p + (80'sd1 <<< 31)) >>> 32;
            c_q[i] = s[46:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q  <= c_q;
            r_c3 <= r_c2;
        end
    end

    // stage 5: negate and saturate the translation column
    always_ff @(posedge i_clk) begin
        logic signed [47:0] nq;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                nq = -$signed({r_q[i][46], r_q[i]});
                o_col[3][i] <= trs_pkg::sat32({{16{nq[47]}}, nq});
                for (int c = 0; c < 3; c++) begin
                    o_col[c][i] <= r_c3[c][i];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/trs_inverse_matrix.sv -----
// Top level: inverse of a translate*rotate*scale transform as four column beats.
// The first column beat is valid once its transform has passed the 17-stage pipeline
//   and the serializer register; the four columns then follow on consecutive cycles
//   while the sink is ready. The four-beat serializer takes the next transform as its
//   last beat goes; the pipeline takes a beat every cycle unless its end is held.
// Reset: synchronous, active low; clears valid bits and the serializer, not data.
`default_nettype none

module trs_inverse_matrix (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave side
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tdata, low bit up: quat_x, quat_y, quat_z, quat_w (16 each),
    // scale_x, scale_y, scale_z (16 each), trans_x, trans_y, trans_z (32 each)
    input  wire logic [207:0] i_s_axis_tdata,
    // master side
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // tdata, low bit up: column_index (2), elem0, elem1, elem2 (32 each),
    // elem3 (17), zero fill (5)
    output logic [119:0]      o_m_axis_tdata,
    output logic              o_m_axis_tlast,   // last_column
    output logic              o_m_axis_tuser    // scale_error
);

    localparam int unsigned NS   = trs_pkg::PIPE_STAGES;
    localparam int unsigned ND   = trs_pkg::DIV_STAGES;
    localparam int unsigned NTD  = ND + trs_pkg::ROT_STAGES;

    // ---------------- pipeline control ----------------
    // One enable moves every stage; a beat waiting at the end holds them all.
    logic [NS-1:0] r_v;
    logic          r_err [NS];
    logic          w_en;
    logic          w_ser_free;
    logic          w_ser_load;
    logic          w_beat;

    // ---------------- input register ----------------
    trs_pkg::t_quat r_qx, r_qy, r_qz, r_qw;
    logic [15:0]    r_sx, r_sy, r_sz;
    trs_pkg::t_vec  r_t;

    // delay lines that ride beside the divider and the rotation stages
    trs_pkg::t_quat r_qd [ND][4];
    trs_pkg::t_vec  r_td [NTD];
    trs_pkg::t_rvec r_rcd [trs_pkg::ROT_STAGES];

    trs_pkg::t_rvec w_recip;
    trs_pkg::t_mat  w_rot;
    trs_pkg::t_cols w_col;

    // ---------------- output serializer ----------------
    logic           r_full;
    logic [1:0]     r_cnt;
    trs_pkg::t_cols r_col;
    logic           r_oerr;

    assign w_beat     = r_full && i_m_axis_tready;
    assign w_ser_free = !r_full || (w_beat && r_cnt == trs_pkg::COL_LAST);
    assign w_en       = !r_v[NS-1] || w_ser_free;
    assign w_ser_load = r_v[NS-1] && w_ser_free;

    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qx <= i_s_axis_tdata[15:0];
            r_qy <= i_s_axis_tdata[31:16];
            r_qz <= i_s_axis_tdata[47:32];
            r_qw <= i_s_axis_tdata[63:48];
            r_sx <= i_s_axis_tdata[79:64];
            r_sy <= i_s_axis_tdata[95:80];
            r_sz <= i_s_axis_tdata[111:96];
            r_t[0] <= i_s_axis_tdata[143:112];
            r_t[1] <= i_s_axis_tdata[175:144];
            r_t[2] <= i_s_axis_tdata[207:176];
            // flag a zero scale on any axis
            r_err[0] <= (i_s_axis_tdata[79:64] == '0) || (i_s_axis_tdata[95:80] == '0)
                     || (i_s_axis_tdata[111:96] == '0);
            for (int k = 1; k < NS; k++) begin
                r_err[k] <= r_err[k-1];
            end

            r_qd[0][0] <= r_qx;
            r_qd[0][1] <= r_qy;
            r_qd[0][2] <= r_qz;
            r_qd[0][3] <= r_qw;
            for (int k = 1; k < ND; k++) begin
                r_qd[k] <= r_qd[k-1];
            end
            r_td[0] <= r_t;
            for (int k = 1; k < NTD; k++) begin
                r_td[k] <= r_td[k-1];
            end
            r_rcd[0] <= w_recip;
            for (int k = 1; k < trs_pkg::ROT_STAGES; k++) begin
                r_rcd[k] <= r_rcd[k-1];
            end
        end
    end

    // reciprocal of each axis scale
    trs_recip u_recip_x (.i_clk(i_clk), .i_en(w_en), .i_scale(r_sx), .o_recip(w_recip[0]));
    trs_recip u_recip_y (.i_clk(i_clk), .i_en(w_en), .i_scale(r_sy), .o_recip(w_recip[1]));
    trs_recip u_recip_z (.i_clk(i_clk), .i_en(w_en), .i_scale(r_sz), .o_recip(w_recip[2]));

    // rotation matrix, built once the quaternion has caught up with the divider
    trs_rot u_rot (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_qx  (r_qd[ND-1][0]),
        .i_qy  (r_qd[ND-1][1]),
        .i_qz  (r_qd[ND-1][2]),
        .i_qw  (r_qd[ND-1][3]),
        .o_rot (w_rot)
    );

    trs_col u_col (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_rot   (w_rot),
        .i_trans (r_td[NTD-1]),
        .i_recip (r_rcd[trs_pkg::ROT_STAGES-1]),
        .o_col   (w_col)
    );

    // Hold one finished transform and send its columns in order; load the next
    // transform on the same edge that the final column is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_cnt  <= '0;
        end else if (w_ser_load) begin
            r_full <= 1'b1;
            r_cnt  <= '0;
        end else if (w_beat) begin
            if (r_cnt == trs_pkg::COL_LAST) begin
                r_full <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ser_load) begin
            r_col  <= w_col;
            r_oerr <= r_err[NS-1];
        end
    end

    assign o_m_axis_tvalid = r_full;
    assign o_m_axis_tlast  = (r_cnt == trs_pkg::COL_LAST);
    assign o_m_axis_tuser  = r_oerr;
    assign o_m_axis_tdata  = {5'b0,
                              (r_cnt == trs_pkg::COL_LAST) ? trs_pkg::ELEM_ONE : 17'd0,
                              r_col[r_cnt][2], r_col[r_cnt][1], r_col[r_cnt][0],
                              r_cnt};

`ifndef SYNTHESIS
    // a stalled column stays put
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !i_m_axis_tready) |=> (r_full && $stable(r_cnt)))
        else $error("serializer moved while stalled");

    // columns advance one at a time within a transform
    a_col_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && r_cnt != trs_pkg::COL_LAST) |=> (r_full && r_cnt == $past(r_cnt) + 2'd1))
        else $error("column index skipped");

    // a finished transform at the pipeline end blocks new input until it moves
    a_end_block : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && !w_ser_free) |-> !o_s_axis_tready)
        else $error("pipeline advanced over a waiting transform");

    // a transform that finishes while the serializer is busy is still there next cycle
    a_end_keep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && !w_ser_free) |=> r_v[NS-1])
        else $error("waiting transform lost");
`endif

endmodule

`default_nettype wire
